// ----- design/assert_macros.svh -----
// Assertion macros shared by the display driver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define SSD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/ssd_pkg.sv -----
// Types, codes and constants of the seven-segment decimal display driver.
package ssd_pkg;

    localparam int NUM_DIGITS_DEF   = 4;
    localparam int SHOWN_DIGITS_DEF = 3;

    localparam int POS_W   = 3;
    localparam int VALUE_W = 16;
    localparam int DIGIT_W = 4;
    localparam int FIXED_W = 24;

    localparam logic [1:0] CMD_SET_INT   = 2'd0;
    localparam logic [1:0] CMD_SET_FIXED = 2'd1;
    localparam logic [1:0] CMD_SET_AUTO  = 2'd2;
    localparam logic [1:0] CMD_TICK      = 2'd3;

    localparam logic [1:0] PLACES_ZERO      = 2'd0;
    localparam logic [1:0] PLACES_ONE       = 2'd1;
    localparam logic [1:0] PLACES_TWO       = 2'd2;
    localparam logic [1:0] PLACES_DOTS_ONLY = 2'd3;

    localparam logic [FIXED_W-1:0] AUTO_TEN_Q     = 24'd2560;
    localparam logic [FIXED_W-1:0] AUTO_HUNDRED_Q = 24'd25600;
    localparam logic [VALUE_W-1:0] SAT_MAX        = 16'hFFFF;

    // Reciprocal of ten: (v * DIV10_MUL) >> DIV10_SHIFT is exact for 16-bit v.
    localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                 DIV10_SHIFT = 19;

    // One word as it travels along the row of digit cells.
    typedef struct packed {
        logic                valid;
        logic                is_tick;
        logic                wr_digits;
        logic                dot_en;
        logic [POS_W-1:0]    dot_pos;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    pos;
        logic [DIGIT_W-1:0]  digit;
        logic                dot;
    } word_t;

endpackage

// ----- design/ssd_front.sv -----
// Entry stage: scaling, saturation, place selection and the refresh counter.
module ssd_front #(
    parameter int SHOWN_DIGITS = ssd_pkg::SHOWN_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          cmd_valid,
    input  logic [1:0]                    command,
    input  logic [ssd_pkg::VALUE_W-1:0]   int_value,
    input  logic [ssd_pkg::FIXED_W-1:0]   fixed_value,
    input  logic [1:0]                    places,
    output ssd_pkg::word_t                head
);

    localparam logic [ssd_pkg::POS_W-1:0] LAST_POS = ssd_pkg::POS_W'(SHOWN_DIGITS - 1);

    logic [ssd_pkg::POS_W-1:0] idx_reg, idx_next;
    ssd_pkg::word_t            head_reg, head_next;
    logic [1:0]                places_eff;
    logic [6:0]                scale;
    logic [30:0]               scaled;
    logic [22:0]               floored;
    logic [ssd_pkg::VALUE_W-1:0] sat_value;
    logic                      is_fixed;
    logic                      accept;
    logic                      tick_taken;

    assign accept     = cmd_valid && en;
    assign tick_taken = accept && (command == ssd_pkg::CMD_TICK);

    always_comb
    begin
        if (fixed_value < ssd_pkg::AUTO_TEN_Q)
            places_eff = ssd_pkg::PLACES_TWO;
        else if (fixed_value < ssd_pkg::AUTO_HUNDRED_Q)
            places_eff = ssd_pkg::PLACES_ONE;
        else
            places_eff = ssd_pkg::PLACES_ZERO;
        if (command == ssd_pkg::CMD_SET_FIXED)
            places_eff = places;
    end

    always_comb
    begin
        case (places_eff)
            ssd_pkg::PLACES_ONE: scale = 7'd10;
            ssd_pkg::PLACES_TWO: scale = 7'd100;
            default:             scale = 7'd1;
        endcase
    end

    // Q16.8 times the scale, then floor by dropping the eight fraction bits.
    assign scaled    = 31'(fixed_value) * 31'(scale);
    assign floored   = scaled[30:8];
    assign sat_value = (|floored[22:16]) ? ssd_pkg::SAT_MAX : floored[15:0];
    assign is_fixed  = (command == ssd_pkg::CMD_SET_FIXED) || (command == ssd_pkg::CMD_SET_AUTO);

    always_comb
    begin
        idx_next = idx_reg;
        if (tick_taken)
        begin
            if (idx_reg == LAST_POS)
                idx_next = '0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        head_next           = head_reg;
        head_next.valid     = accept;
        head_next.is_tick   = (command == ssd_pkg::CMD_TICK);
        head_next.wr_digits = (command == ssd_pkg::CMD_SET_INT)
                              || (is_fixed && places_eff != ssd_pkg::PLACES_DOTS_ONLY);
        head_next.dot_en    = is_fixed && (places_eff == ssd_pkg::PLACES_ONE
                                           || places_eff == ssd_pkg::PLACES_TWO);
        head_next.dot_pos   = ssd_pkg::POS_W'(places_eff);
        head_next.value     = (command == ssd_pkg::CMD_SET_INT) ? int_value : sat_value;
        head_next.pos       = idx_next;
        head_next.digit     = '0;
        head_next.dot       = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            head_reg <= '0;
        end
        else if (en)
        begin
            idx_reg  <= idx_next;
            head_reg <= head_next;
        end
    end

    assign head = head_reg;

    `include "assert_macros.svh"

    `SSD_ASSERT(a_idx_range, idx_reg <= LAST_POS, "refresh counter left its range")
    `SSD_ASSERT(a_idx_hold, !tick_taken |=> $stable(idx_reg), "counter moved without a tick")

endmodule

// ----- design/ssd_cell.sv -----
// One digit cell: holds a digit and its dot, peels off one decimal digit per word.
module ssd_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ssd_pkg::word_t prev,
    output ssd_pkg::word_t next
);

    localparam logic [ssd_pkg::POS_W-1:0] MY_POS = ssd_pkg::POS_W'(CELL_INDEX);

    logic [ssd_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic                        dot_reg, dot_next;
    ssd_pkg::word_t              word_reg, word_next;
    logic [31:0]                 prod;
    logic [ssd_pkg::VALUE_W-1:0] quot;
    logic [ssd_pkg::VALUE_W-1:0] rem_wide;

    // Divide by ten with the reciprocal; times ten is two shifts and an add.
    assign prod     = 32'(prev.value) * 32'(ssd_pkg::DIV10_MUL);
    assign quot     = ssd_pkg::VALUE_W'(prod[31:ssd_pkg::DIV10_SHIFT]);
    assign rem_wide = prev.value - ((quot << 3) + (quot << 1));

    always_comb
    begin
        digit_next = digit_reg;
        dot_next   = dot_reg;
        word_next  = prev;
        if (prev.valid && !prev.is_tick)
        begin
            if (prev.wr_digits)
                digit_next = rem_wide[ssd_pkg::DIGIT_W-1:0];
            dot_next        = prev.dot_en && (prev.dot_pos == MY_POS);
            word_next.value = quot;
        end
        if (prev.valid && prev.is_tick && prev.pos == MY_POS)
        begin
            word_next.digit = digit_reg;
            word_next.dot   = dot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            dot_reg   <= 1'b0;
            word_reg  <= '0;
        end
        else if (en)
        begin
            digit_reg <= digit_next;
            dot_reg   <= dot_next;
            word_reg  <= word_next;
        end
    end

    assign next = word_reg;

    `include "assert_macros.svh"

    `SSD_ASSERT_NEVER(a_digit_decimal, digit_reg > 4'd9, "stored digit is not decimal")

endmodule

// ----- design/seven_segment_decimal_display.sv -----
// Top level of the seven-segment decimal display driver.
//
//   Channel   Handshake               Fields
//   command   cmd_valid / cmd_stall   command, int_value, fixed_value, places
//   display   disp_valid / disp_stall digit_position, digit_value, dot_on
//
// One word is taken per cycle while cmd_stall is low. A word runs through the entry stage,
// then one cell per stored digit and then the output register, which presents a tick's result.
// Set words and ticks pass each cell in order, so a tick sees every earlier set.
// While the output register holds a result that is stalled, the whole row stands still
// and cmd_stall is high. Reset clears all digits, dots and the refresh counter at once.
module seven_segment_decimal_display #(
    parameter int NUM_DIGITS   = ssd_pkg::NUM_DIGITS_DEF,
    parameter int SHOWN_DIGITS = ssd_pkg::SHOWN_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [1:0]                    command,
    input  logic [ssd_pkg::VALUE_W-1:0]   int_value,
    input  logic [ssd_pkg::FIXED_W-1:0]   fixed_value,
    input  logic [1:0]                    places,
    output logic                          disp_valid,
    input  logic                          disp_stall,
    output logic [1:0]                    digit_position,
    output logic [ssd_pkg::DIGIT_W-1:0]   digit_value,
    output logic                          dot_on
);

    ssd_pkg::word_t chain [0:NUM_DIGITS];
    ssd_pkg::word_t tail;
    logic           en;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     pos_reg;
    logic [ssd_pkg::DIGIT_W-1:0] digit_reg;
    logic           dot_reg;
    logic           dot_place_ok;
    logic           stalled;
    logic [ssd_pkg::DIGIT_W+2:0] disp_word;

    assign en        = !out_valid_reg || !disp_stall;
    assign cmd_stall = !en;

    ssd_front #(
        .SHOWN_DIGITS (SHOWN_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .cmd_valid   (cmd_valid),
        .command     (command),
        .int_value   (int_value),
        .fixed_value (fixed_value),
        .places      (places),
        .head        (chain[0])
    );

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        ssd_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[k]),
            .next  (chain[k+1])
        );
    end

    assign tail           = chain[NUM_DIGITS];
    assign out_valid_next = tail.valid && tail.is_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && out_valid_next)
        begin
            pos_reg   <= tail.pos[1:0];
            digit_reg <= tail.digit;
            dot_reg   <= tail.dot;
        end
    end

    assign disp_valid     = out_valid_reg;
    assign digit_position = pos_reg;
    assign digit_value    = digit_reg;
    assign dot_on         = dot_reg;

    assign dot_place_ok = (digit_position == 2'd1) || (digit_position == 2'd2);
    assign stalled      = disp_valid && disp_stall;
    assign disp_word    = {digit_position, digit_value, dot_on};

    `include "assert_macros.svh"

    `SSD_ASSERT_NEVER(a_out_digit, disp_valid && digit_value > 4'd9, "shown digit is not decimal")
    `SSD_ASSERT(a_dot_place, disp_valid && dot_on |-> dot_place_ok, "dot lit at a wrong place")
    `SSD_ASSERT(a_freeze, stalled |=> disp_valid && $stable(disp_word), "stalled word changed")

endmodule

// ----- bench/tb_seven_segment_decimal_display.sv -----
// Self-checking testbench for the seven-segment decimal display driver.
`timescale 1ns / 100ps

module tb_seven_segment_decimal_display;

    localparam int ROW_LATENCY = ssd_pkg::NUM_DIGITS_DEF + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 800;

    typedef struct {
        logic [1:0]                  position;
        logic [ssd_pkg::DIGIT_W-1:0] value;
        logic                        dot;
    } shown_digit_t;

    class display_scoreboard;
        logic [ssd_pkg::DIGIT_W-1:0] digits [ssd_pkg::NUM_DIGITS_DEF];
        logic                        dots [ssd_pkg::NUM_DIGITS_DEF];
        int unsigned                 refresh_pos;
        shown_digit_t                due_digits [$];
        int                          failures;
        int                          compared;
        int                          ticks;

        function new();
            foreach (digits[k])
            begin
                digits[k] = '0;
                dots[k] = 1'b0;
            end
            refresh_pos = 0;
            failures = 0;
            compared = 0;
            ticks = 0;
        endfunction

        function void load_integer(logic [ssd_pkg::VALUE_W-1:0] v);
            int unsigned rest;
            rest = v;
            foreach (digits[k])
            begin
                digits[k] = ssd_pkg::DIGIT_W'(rest % 10);
                rest = rest / 10;
                dots[k] = 1'b0;
            end
        endfunction

        function void load_fixed(logic [ssd_pkg::FIXED_W-1:0] q, logic [1:0] pl);
            logic [31:0] scale;
            logic [31:0] scaled;
            foreach (dots[k])
                dots[k] = 1'b0;
            if (pl == ssd_pkg::PLACES_DOTS_ONLY)
                return;
            scale = (pl == ssd_pkg::PLACES_ZERO) ? 32'd1
                    : ((pl == ssd_pkg::PLACES_ONE) ? 32'd10 : 32'd100);
            scaled = ({8'd0, q} * scale) >> 8;
            if (scaled > {16'd0, ssd_pkg::SAT_MAX})
                scaled = {16'd0, ssd_pkg::SAT_MAX};
            load_integer(scaled[ssd_pkg::VALUE_W-1:0]);
            if (pl != ssd_pkg::PLACES_ZERO && int'(pl) < ssd_pkg::NUM_DIGITS_DEF)
                dots[pl] = 1'b1;
        endfunction

        function void note_word(logic [1:0] cmd, logic [ssd_pkg::VALUE_W-1:0] iv,
                                logic [ssd_pkg::FIXED_W-1:0] fv, logic [1:0] pl);
            shown_digit_t due;
            case (cmd)
                ssd_pkg::CMD_SET_INT:   load_integer(iv);
                ssd_pkg::CMD_SET_FIXED: load_fixed(fv, pl);
                ssd_pkg::CMD_SET_AUTO:
                begin
                    if (fv < ssd_pkg::AUTO_TEN_Q)
                        load_fixed(fv, ssd_pkg::PLACES_TWO);
                    else if (fv < ssd_pkg::AUTO_HUNDRED_Q)
                        load_fixed(fv, ssd_pkg::PLACES_ONE);
                    else
                        load_fixed(fv, ssd_pkg::PLACES_ZERO);
                end
                ssd_pkg::CMD_TICK:
                begin
                    // The counter moves on before the stored digit is read.
                    refresh_pos = (refresh_pos + 1) % ssd_pkg::SHOWN_DIGITS_DEF;
                    due.position = 2'(refresh_pos);
                    due.value = '0;
                    due.dot = 1'b0;
                    if (refresh_pos < ssd_pkg::NUM_DIGITS_DEF)
                    begin
                        due.value = digits[refresh_pos];
                        due.dot = dots[refresh_pos];
                    end
                    due_digits.push_back(due);
                    ticks++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] pos, logic [ssd_pkg::DIGIT_W-1:0] val,
                                   logic dot);
            shown_digit_t due;
            if (due_digits.size() == 0)
            begin
                $error("unexpected display word: position %0d digit %0d dot %0d",
                       pos, val, dot);
                failures++;
                return;
            end
            due = due_digits.pop_front();
            compared++;
            if (pos !== due.position)
            begin
                $error("digit_position: expected %0d, got %0d", due.position, pos);
                failures++;
            end
            if (val !== due.value)
            begin
                $error("digit_value: expected %0d, got %0d", due.value, val);
                failures++;
            end
            if (dot !== due.dot)
            begin
                $error("dot_on: expected %0d, got %0d", due.dot, dot);
                failures++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cmd_valid = 1'b0;
    logic                        cmd_stall;
    logic [1:0]                  command = ssd_pkg::CMD_SET_INT;
    logic [ssd_pkg::VALUE_W-1:0] int_value = '0;
    logic [ssd_pkg::FIXED_W-1:0] fixed_value = '0;
    logic [1:0]                  places = ssd_pkg::PLACES_ZERO;
    logic                        disp_valid;
    logic                        disp_stall = 1'b0;
    logic [1:0]                  digit_position;
    logic [ssd_pkg::DIGIT_W-1:0] digit_value;
    logic                        dot_on;

    display_scoreboard board;
    logic              calm = 1'b0;
    int                words_sent = 0;
    int                cycle_count = 0;

    seven_segment_decimal_display uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .int_value      (int_value),
        .fixed_value    (fixed_value),
        .places         (places),
        .disp_valid     (disp_valid),
        .disp_stall     (disp_stall),
        .digit_position (digit_position),
        .digit_value    (digit_value),
        .dot_on         (dot_on)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // The display side stalls at random, except during the calm stretch.
    initial
    begin
        forever
        begin
            @(negedge clk);
            disp_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && disp_valid && !disp_stall)
            board.check_result(digit_position, digit_value, dot_on);
    end

    // Entered and left at a falling edge.
    task automatic send_word(input logic [1:0] cmd, input logic [ssd_pkg::VALUE_W-1:0] iv,
                             input logic [ssd_pkg::FIXED_W-1:0] fv, input logic [1:0] pl);
        while (!calm && $urandom_range(99) < 32)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        command <= cmd;
        int_value <= iv;
        fixed_value <= fv;
        places <= pl;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_word(cmd, iv, fv, pl);
        words_sent++;
        @(negedge clk);
    endtask

    // Ticks carry random noise in the fields that they do not use.
    task automatic send_ticks(input int count);
        repeat (count)
            send_word(ssd_pkg::CMD_TICK, ssd_pkg::VALUE_W'($urandom),
                      ssd_pkg::FIXED_W'($urandom), 2'($urandom));
    endtask

    task automatic send_random_set();
        logic [1:0]                  cmd;
        logic [ssd_pkg::FIXED_W-1:0] fv;
        logic [1:0]                  pl;
        case ($urandom_range(2))
            0: cmd = ssd_pkg::CMD_SET_INT;
            1: cmd = ssd_pkg::CMD_SET_FIXED;
            default: cmd = ssd_pkg::CMD_SET_AUTO;
        endcase
        // Mostly values that do not saturate, so the digit split gets exercised.
        case ($urandom_range(4))
            0: fv = ssd_pkg::FIXED_W'($urandom);
            1: fv = ssd_pkg::FIXED_W'($urandom_range(2600));
            2: fv = ssd_pkg::FIXED_W'($urandom_range(26000));
            3: fv = ssd_pkg::FIXED_W'($urandom_range(167772));
            default: fv = ssd_pkg::FIXED_W'($urandom_range(16777215, 16000000));
        endcase
        pl = ($urandom_range(9) == 0) ? ssd_pkg::PLACES_DOTS_ONLY : 2'($urandom_range(2));
        send_word(cmd, ssd_pkg::VALUE_W'($urandom), fv, pl);
    endtask

    initial
    begin
        board = new();
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: reset contents, extremes, saturation and the auto thresholds.
        send_ticks(1);
        send_word(ssd_pkg::CMD_SET_INT, 16'hFFFF, '0, ssd_pkg::PLACES_ZERO);
        send_ticks(3);
        send_word(ssd_pkg::CMD_SET_FIXED, '0, 24'hFFFFFF, ssd_pkg::PLACES_TWO);
        send_ticks(2);
        send_word(ssd_pkg::CMD_SET_FIXED, 16'hFFFF, 24'h000000, ssd_pkg::PLACES_DOTS_ONLY);
        send_ticks(2);
        send_word(ssd_pkg::CMD_SET_FIXED, '0, 24'h000314, ssd_pkg::PLACES_ONE);
        send_ticks(2);
        send_word(ssd_pkg::CMD_SET_AUTO, '0, 24'd2559, ssd_pkg::PLACES_ZERO);
        send_ticks(1);
        send_word(ssd_pkg::CMD_SET_AUTO, '0, 24'd2560, ssd_pkg::PLACES_TWO);
        send_ticks(1);
        send_word(ssd_pkg::CMD_SET_AUTO, '0, 24'd25599, ssd_pkg::PLACES_ZERO);
        send_word(ssd_pkg::CMD_SET_AUTO, '0, 24'd25600, ssd_pkg::PLACES_ONE);
        send_ticks(1);
        send_word(ssd_pkg::CMD_SET_FIXED, '0, 24'hFFFFFF, ssd_pkg::PLACES_ZERO);
        send_word(ssd_pkg::CMD_SET_INT, '0, 24'hFFFFFF, ssd_pkg::PLACES_DOTS_ONLY);
        send_ticks(1);

        // Random part: mostly a set word followed by ticks that read it back.
        while (words_sent < RANDOM_WORDS + 25)
        begin
            calm <= (words_sent > 300 && words_sent < 480);
            if ($urandom_range(99) < 80)
            begin
                send_random_set();
                send_ticks($urandom_range(4, 1));
            end
            else if ($urandom_range(1) == 0)
                send_random_set();
            else
                send_ticks(1);
        end
        cmd_valid <= 1'b0;
        calm <= 1'b0;

        while (board.due_digits.size() != 0)
            @(posedge clk);
        repeat (ROW_LATENCY * 4)
            @(posedge clk);

        $display("Sent %0d command words, %0d of them refresh ticks.", words_sent, board.ticks);
        $display("Compared %0d display words against the predicted digits and dots.",
                 board.compared);
        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
